### rtl/core/ben_pkg.sv
package ben_pkg;

    localparam int NODE_SLOTS = 8;
    localparam int MAX_NODES  = 8;
    localparam int LIVE_LIMIT = (MAX_NODES < NODE_SLOTS) ? MAX_NODES : NODE_SLOTS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;

    localparam logic [2:0] OWN_ID_RST     = 3'd0;
    localparam logic [3:0] PROC_COUNT_RST = 4'd5;
    localparam logic [7:0] TIMEOUT_RST    = 8'd5;
    localparam logic [8:0] IDLE_RST       = 9'h1FF;
    localparam logic [8:0] IDLE_MAX       = 9'd255;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_HELLO = 3'd1;
    localparam logic [2:0] KIND_ELECT = 3'd2;
    localparam logic [2:0] KIND_COORD = 3'd3;
    localparam logic [2:0] KIND_ALIVE = 3'd4;

    localparam logic [1:0] OUT_ELECT  = 2'd0;
    localparam logic [1:0] OUT_ALIVE  = 2'd1;
    localparam logic [1:0] OUT_COORD  = 2'd2;
    localparam logic [1:0] OUT_INSTAB = 2'd3;

    typedef struct packed {
        logic [2:0] message_kind;
        logic [2:0] sender_id;
        logic [7:0] alive_mask;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] dest_id;
        logic [1:0] out_kind;
        logic       last;
    } out_beat_t;

    typedef logic [3:0] upc_t;

    // microprogram addresses
    localparam upc_t A_FETCH   = 4'd0;
    localparam upc_t A_DISP    = 4'd1;
    localparam upc_t A_ALV_LD  = 4'd2;
    localparam upc_t A_ALV_TX  = 4'd3;
    localparam upc_t A_UP_LD   = 4'd4;
    localparam upc_t A_UP_TX   = 4'd5;
    localparam upc_t A_CLR     = 4'd6;
    localparam upc_t A_AWT     = 4'd7;
    localparam upc_t A_TMO     = 4'd8;
    localparam upc_t A_TMO_SEL = 4'd9;
    localparam upc_t A_CRD_LD  = 4'd10;
    localparam upc_t A_CRD_TX  = 4'd11;
    localparam upc_t A_TMO_B   = 4'd12;
    localparam upc_t A_END     = 4'd13;
    localparam upc_t A_INS_LD  = 4'd14;
    localparam upc_t A_INS_TX  = 4'd15;

    typedef enum logic [2:0] {
        TGT_NONE,
        TGT_SENDER,
        TGT_UP,
        TGT_COORD,
        TGT_SELF
    } tgt_sel_t;

    typedef enum logic [1:0] {
        IDLE_KEEP,
        IDLE_STEP,
        IDLE_CLR
    } idle_op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_DISPATCH,
        COND_IN_ELECT,
        COND_NOT_TMO_A,
        COND_LAST_NODE,
        COND_TMO_B
    } cond_t;

    typedef struct packed {
        logic       take;
        tgt_sel_t   tgt;
        logic [1:0] kind;
        logic       emit;
        logic       set_elect;
        logic       clr_elect;
        logic       set_await;
        logic       clr_await;
        idle_op_t   idle;
        cond_t      cond;
        upc_t       jump;
    } uword_t;

    typedef struct packed {
        logic in_beat;
        logic tgt_empty;
        logic in_elect;
        logic tmo_a;
        logic tmo_b;
        logic last_node;
        upc_t map;
    } seq_stat_t;

    function automatic uword_t ucode(upc_t a);
        uword_t w;
        w = '0;
        unique case (a)
            A_FETCH:   begin w.take = 1'b1; end
            A_DISP:    begin w.idle = IDLE_STEP; w.cond = COND_DISPATCH; end
            A_ALV_LD:  begin w.tgt = TGT_SENDER; end
            A_ALV_TX:  begin
                w.emit = 1'b1; w.kind = OUT_ALIVE;
                w.cond = COND_IN_ELECT; w.jump = A_FETCH;
            end
            A_UP_LD:   begin w.tgt = TGT_UP; w.set_elect = 1'b1; end
            A_UP_TX:   begin
                w.emit = 1'b1; w.kind = OUT_ELECT;
                w.cond = COND_ALWAYS; w.jump = A_FETCH;
            end
            A_CLR:     begin
                w.clr_elect = 1'b1; w.clr_await = 1'b1;
                w.cond = COND_ALWAYS; w.jump = A_FETCH;
            end
            A_AWT:     begin
                w.set_await = 1'b1; w.clr_elect = 1'b1;
                w.cond = COND_ALWAYS; w.jump = A_FETCH;
            end
            A_TMO:     begin w.cond = COND_NOT_TMO_A; w.jump = A_TMO_B; end
            A_TMO_SEL: begin w.cond = COND_LAST_NODE; w.jump = A_INS_LD; end
            A_CRD_LD:  begin
                w.tgt = TGT_COORD; w.idle = IDLE_CLR; w.clr_elect = 1'b1;
            end
            A_CRD_TX:  begin
                w.emit = 1'b1; w.kind = OUT_COORD;
                w.cond = COND_ALWAYS; w.jump = A_FETCH;
            end
            A_TMO_B:   begin w.cond = COND_TMO_B; w.jump = A_UP_LD; end
            A_END:     begin w.cond = COND_ALWAYS; w.jump = A_FETCH; end
            A_INS_LD:  begin w.tgt = TGT_SELF; end
            A_INS_TX:  begin
                w.emit = 1'b1; w.kind = OUT_INSTAB;
                w.cond = COND_ALWAYS; w.jump = A_FETCH;
            end
            default:   begin w = '0; end
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch_addr(logic [2:0] kind, logic [2:0] from,
                                           logic [2:0] own);
        upc_t a;
        unique case (kind)
            KIND_TICK:  a = A_TMO;
            KIND_HELLO: a = A_UP_LD;
            KIND_ELECT: a = (from < own) ? A_ALV_LD : A_FETCH;
            KIND_COORD: a = (from < own) ? A_UP_LD : A_CLR;
            KIND_ALIVE: a = A_AWT;
            default:    a = A_FETCH;
        endcase
        return a;
    endfunction

    function automatic logic [NODE_SLOTS-1:0] target_mask(tgt_sel_t sel,
            logic [2:0] own, logic [3:0] pcnt, logic [2:0] from, logic [7:0] alive);
        logic [NODE_SLOTS-1:0] t;
        logic                  live;
        logic                  below;
        t = '0;
        for (int i = 0; i < NODE_SLOTS; i++) begin
            live  = alive[i] && (i < LIVE_LIMIT);
            below = 4'(i) < pcnt;
            unique case (sel)
                TGT_SENDER: t[i] = live && (3'(i) == from);
                TGT_UP:     t[i] = live && below && (3'(i) > own);
                TGT_COORD:  t[i] = live && below && (3'(i) != own);
                TGT_SELF:   t[i] = (3'(i) == own);
                default:    t[i] = 1'b0;
            endcase
        end
        return t;
    endfunction

    function automatic logic [2:0] lowest_set(logic [NODE_SLOTS-1:0] v);
        logic [2:0] idx;
        idx = '0;
        for (int i = NODE_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) idx = 3'(i);
        end
        return idx;
    endfunction

endpackage

### rtl/core/ben_useq.sv
module ben_useq (
    input  logic              aclk,
    input  logic              aresetn,
    input  ben_pkg::seq_stat_t stat,
    output ben_pkg::uword_t   ctl
);
    import ben_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    upc_t upc_inc;

    assign ctl     = ucode(upc_reg);
    assign upc_inc = upc_reg + 4'd1;

    always_comb begin
        upc_next = upc_inc;
        if (ctl.take && !stat.in_beat) begin
            upc_next = upc_reg;
        end else if (ctl.emit && !stat.tgt_empty) begin
            upc_next = upc_reg;
        end else begin
            unique case (ctl.cond)
                COND_NEXT:      upc_next = upc_inc;
                COND_ALWAYS:    upc_next = ctl.jump;
                COND_DISPATCH:  upc_next = stat.map;
                COND_IN_ELECT:  upc_next = stat.in_elect  ? ctl.jump : upc_inc;
                COND_NOT_TMO_A: upc_next = !stat.tmo_a    ? ctl.jump : upc_inc;
                COND_LAST_NODE: upc_next = stat.last_node ? ctl.jump : upc_inc;
                COND_TMO_B:     upc_next = stat.tmo_b     ? ctl.jump : A_END;
                default:        upc_next = A_FETCH;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= A_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

### rtl/core/bully_election_node_core.sv
// One node of a bully leader election group.
// Input channel (s_*): one beat per tick or received message, with sender
// and the alive mask. Result channel (m_*): zero to seven message beats per
// input beat, in ascending dest_id order, last set on the final one; an
// input that causes nothing gives no result beat.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write own_id, process_count
// and timeout_ticks; write only while the node is idle.
// A microcoded sequencer (16-word control store) runs one input at a time.
// The result register holds its beat while m_ready is low; the sequencer
// waits on it and resumes without loss when the sink takes the beat.
// Reset: registers return to own_id 0, process_count 5, timeout 5, idle
// counter -1 and both election flags clear; no result is pending.
module bully_election_node_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ben_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ben_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ben_pkg::in_beat_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ben_pkg::out_beat_t                 m_data
);
    import ben_pkg::*;

    uword_t    ctl;
    seq_stat_t stat;

    logic [2:0]            own_reg, own_next;
    logic [3:0]            pc_reg, pc_next;
    logic [7:0]            tmo_reg, tmo_next;
    in_beat_t              in_reg, in_next;
    logic [8:0]            idle_reg, idle_next;
    logic                  in_elect_reg, in_elect_next;
    logic                  await_reg, await_next;
    logic [NODE_SLOTS-1:0] tgt_reg, tgt_next;
    logic                  follow_reg, follow_next;
    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_data_reg, m_data_next;

    logic                  in_beat;
    logic                  drain;
    logic [NODE_SLOTS-1:0] tgt_rest;
    logic [NODE_SLOTS-1:0] up_mask;

    ben_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    assign s_ready = ctl.take;
    assign in_beat = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign up_mask  = target_mask(TGT_UP, own_reg, pc_reg, in_reg.sender_id,
                                  in_reg.alive_mask);
    assign tgt_rest = tgt_reg & (tgt_reg - NODE_SLOTS'(1));
    assign drain    = ctl.emit && (tgt_reg != '0) && (!m_valid_reg || m_ready);

    always_comb begin
        stat.in_beat   = in_beat;
        stat.tgt_empty = (tgt_reg == '0);
        stat.in_elect  = in_elect_reg;
        stat.tmo_a     = (idle_reg == {1'b0, tmo_reg}) && in_elect_reg;
        stat.tmo_b     = ({1'b0, idle_reg} == ({2'b00, tmo_reg} + 10'd1)) && await_reg;
        stat.last_node = (({1'b0, own_reg} + 4'd1) == pc_reg);
        stat.map       = dispatch_addr(in_reg.message_kind, in_reg.sender_id, own_reg);
    end

    // configuration
    always_comb begin
        own_next = own_reg;
        pc_next  = pc_reg;
        tmo_next = tmo_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_OWN_ID:     own_next = cfg_wdata[2:0];
                REG_PROC_COUNT: pc_next  = cfg_wdata[3:0];
                REG_TIMEOUT:    tmo_next = cfg_wdata[7:0];
                default:        ;
            endcase
        end
    end

    // node state
    always_comb begin
        in_next       = in_beat ? s_data : in_reg;
        idle_next     = idle_reg;
        in_elect_next = in_elect_reg;
        await_next    = await_reg;

        unique case (ctl.idle)
            IDLE_STEP: begin
                if (in_reg.message_kind == KIND_TICK) begin
                    if ((in_elect_reg || await_reg) && idle_reg != IDLE_MAX)
                        idle_next = idle_reg + 9'd1;
                end else begin
                    idle_next = IDLE_RST;
                end
            end
            IDLE_CLR: idle_next = IDLE_RST;
            default:  idle_next = idle_reg;
        endcase

        if (ctl.set_elect)      in_elect_next = 1'b1;
        else if (ctl.clr_elect) in_elect_next = 1'b0;
        if (ctl.set_await)      await_next = 1'b1;
        else if (ctl.clr_await) await_next = 1'b0;
    end

    // destination set and result register
    always_comb begin
        tgt_next     = tgt_reg;
        follow_next  = follow_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (ctl.tgt != TGT_NONE) begin
            tgt_next    = target_mask(ctl.tgt, own_reg, pc_reg, in_reg.sender_id,
                                      in_reg.alive_mask);
            // alive reply is followed by an upward broadcast when not electing
            follow_next = (ctl.tgt == TGT_SENDER) && !in_elect_reg && (up_mask != '0);
        end

        if (m_ready) m_valid_next = 1'b0;
        if (drain) begin
            tgt_next             = tgt_rest;
            m_valid_next         = 1'b1;
            m_data_next.dest_id  = lowest_set(tgt_reg);
            m_data_next.out_kind = ctl.kind;
            m_data_next.last     = (tgt_rest == '0) && !follow_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg      <= OWN_ID_RST;
            pc_reg       <= PROC_COUNT_RST;
            tmo_reg      <= TIMEOUT_RST;
            idle_reg     <= IDLE_RST;
            in_elect_reg <= 1'b0;
            await_reg    <= 1'b0;
            tgt_reg      <= '0;
            follow_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            own_reg      <= own_next;
            pc_reg       <= pc_next;
            tmo_reg      <= tmo_next;
            idle_reg     <= idle_next;
            in_elect_reg <= in_elect_next;
            await_reg    <= await_next;
            tgt_reg      <= tgt_next;
            follow_reg   <= follow_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    ap_idle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idle_reg[8] |-> idle_reg == IDLE_RST)
        else $error("idle counter negative but not -1");

    ap_fetch_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (tgt_reg == '0) && !follow_reg)
        else $error("input taken with destinations still pending");

    ap_follow_not_electing: assert property (@(posedge aclk) disable iff (!aresetn)
        follow_reg |-> !in_elect_reg)
        else $error("broadcast pending while election already running");
`endif

endmodule

### tb/bully_election_node_core_test.sv
module bully_election_node_core_test;
    import ben_pkg::*;

    localparam int NODE_LIMIT     = 8;
    localparam int IDLE_CEIL      = 255;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [2:0] KIND_OTHER  = 3'd5;
    localparam logic [2:0] KIND_RSVD_A = 3'd6;
    localparam logic [2:0] KIND_RSVD_B = 3'd7;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr  = '0;
    logic [7:0] cfg_wdata = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_beat_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_beat_t  m_data;

    // node state and settings as the node should hold them
    logic [2:0] own_id_q = OWN_ID_RST;
    logic [3:0] pcnt_q   = PROC_COUNT_RST;
    logic [7:0] tmo_q    = TIMEOUT_RST;
    int         idle_cnt = -1;
    bit         in_elect;
    bit         awaiting;

    out_beat_t  step_msgs[$];
    out_beat_t  expected_msgs[$];

    bit no_gaps;
    int errors;
    int items_sent;
    int msgs_checked;
    int settings_used;

    bully_election_node_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit node_up(int i, logic [7:0] mask);
        return (i < NODE_LIMIT) && mask[i];
    endfunction

    function automatic void add_msg(logic [2:0] dest, logic [1:0] kind);
        out_beat_t m;
        if (step_msgs.size() >= 7) return;
        m.dest_id  = dest;
        m.out_kind = kind;
        m.last     = 1'b0;
        step_msgs.push_back(m);
    endfunction

    function automatic void elect_upward(logic [7:0] mask);
        for (int i = int'(own_id_q) + 1; i < int'(pcnt_q) && i < NODE_LIMIT; i++) begin
            if (node_up(i, mask)) add_msg(3'(i), OUT_ELECT);
        end
        in_elect = 1'b1;
    endfunction

    function automatic void node_step(in_beat_t beat);
        step_msgs.delete();
        if (beat.message_kind == KIND_TICK) begin
            if ((in_elect || awaiting) && idle_cnt < IDLE_CEIL) idle_cnt++;
        end else begin
            idle_cnt = -1;
            case (beat.message_kind)
                KIND_HELLO: begin
                    elect_upward(beat.alive_mask);
                end
                KIND_ELECT: begin
                    if (beat.sender_id < own_id_q) begin
                        if (node_up(int'(beat.sender_id), beat.alive_mask))
                            add_msg(beat.sender_id, OUT_ALIVE);
                        if (!in_elect) elect_upward(beat.alive_mask);
                    end
                end
                KIND_COORD: begin
                    if (beat.sender_id < own_id_q) begin
                        elect_upward(beat.alive_mask);
                    end else begin
                        in_elect = 1'b0;
                        awaiting = 1'b0;
                    end
                end
                KIND_ALIVE: begin
                    awaiting = 1'b1;
                    in_elect = 1'b0;
                end
                default: ;
            endcase
        end

        if (idle_cnt == int'(tmo_q) && in_elect) begin
            if (int'(own_id_q) + 1 == int'(pcnt_q)) begin
                add_msg(own_id_q, OUT_INSTAB);
            end else begin
                for (int i = 0; i < int'(pcnt_q) && i < NODE_LIMIT; i++) begin
                    if (i != int'(own_id_q) && node_up(i, beat.alive_mask))
                        add_msg(3'(i), OUT_COORD);
                end
                idle_cnt = -1;
                in_elect = 1'b0;
            end
        end
        if (idle_cnt == int'(tmo_q) + 1 && awaiting) elect_upward(beat.alive_mask);

        if (step_msgs.size() > 0) step_msgs[step_msgs.size() - 1].last = 1'b1;
        foreach (step_msgs[k]) expected_msgs.push_back(step_msgs[k]);
    endfunction

    function automatic logic [7:0] pick_mask();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 8'h00;
        if (r < 3) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic deliver_msg(logic [2:0] kind, logic [2:0] from, logic [7:0] mask);
        in_beat_t beat;
        int       gap;
        beat.message_kind = kind;
        beat.sender_id    = from;
        beat.alive_mask   = mask;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        node_step(beat);
        items_sent++;
    endtask

    // stop sending, wait for every outstanding beat, let the sequencer settle
    task automatic drain_node();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_msgs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_node(logic [2:0] own, logic [3:0] pcnt, logic [7:0] tmo);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_OWN_ID;
        cfg_wdata <= 8'(own);
        @(negedge aclk);
        cfg_addr  <= REG_PROC_COUNT;
        cfg_wdata <= 8'(pcnt);
        @(negedge aclk);
        cfg_addr  <= REG_TIMEOUT;
        cfg_wdata <= tmo;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        own_id_q = own;
        pcnt_q   = pcnt;
        tmo_q    = tmo;
        settings_used++;
    endtask

    task automatic check_reset_defaults();
        deliver_msg(KIND_HELLO, 3'd0, 8'hFF);
        repeat (7) deliver_msg(KIND_TICK, 3'd0, 8'hFF);
        deliver_msg(KIND_ELECT, 3'd7, 8'hFF);
    endtask

    task automatic check_message_kinds();
        drain_node();
        set_node(3'd3, 4'd8, 8'd2);
        deliver_msg(KIND_ELECT, 3'd1, 8'hFF);
        deliver_msg(KIND_ELECT, 3'd1, 8'hFF);
        deliver_msg(KIND_ELECT, 3'd2, 8'hFB);
        deliver_msg(KIND_ELECT, 3'd5, 8'hFF);
        deliver_msg(KIND_ELECT, 3'd3, 8'hFF);
        deliver_msg(KIND_COORD, 3'd6, 8'hFF);
        deliver_msg(KIND_COORD, 3'd0, 8'h00);
        deliver_msg(KIND_COORD, 3'd0, 8'hA5);
        deliver_msg(KIND_ALIVE, 3'd7, 8'h5A);
        repeat (5) deliver_msg(KIND_TICK, 3'd7, 8'hFF);
        deliver_msg(KIND_OTHER, 3'd4, 8'hFF);
        deliver_msg(KIND_RSVD_A, 3'd2, 8'h0F);
        deliver_msg(KIND_RSVD_B, 3'd1, 8'hF0);
        deliver_msg(KIND_HELLO, 3'd7, 8'h00);
    endtask

    task automatic check_instability();
        drain_node();
        set_node(3'd7, 4'd8, 8'd1);
        deliver_msg(KIND_HELLO, 3'd0, 8'hFF);
        repeat (3) deliver_msg(KIND_TICK, 3'd0, 8'hFF);
        drain_node();
        set_node(3'd2, 4'd3, 8'd1);
        deliver_msg(KIND_HELLO, 3'd0, 8'hFF);
        repeat (3) deliver_msg(KIND_TICK, 3'd0, 8'h00);
    endtask

    // counter climbs to its ceiling, then a few ticks sit on it
    task automatic check_idle_saturation();
        drain_node();
        set_node(3'd2, 4'd8, 8'd250);
        no_gaps = 1'b1;
        deliver_msg(KIND_ALIVE, 3'd6, 8'hFF);
        repeat (258) deliver_msg(KIND_TICK, 3'($urandom), pick_mask());
        no_gaps = 1'b0;
    endtask

    task automatic run_random_traffic();
        int budget;
        int r;
        int run;
        for (int phase = 0; phase < 3; phase++) begin
            drain_node();
            case (phase)
                0: set_node(3'd0, 4'd8, 8'd1);
                1: set_node(3'd5, 4'd6, 8'd3);
                default: set_node(3'($urandom_range(0, 7)), 4'($urandom_range(1, 8)),
                                  8'($urandom_range(1, 6)));
            endcase
            budget = 8;
            while (budget > 0) begin
                if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
                if ($urandom_range(0, 29) == 0) drain_node();
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    run = $urandom_range(1, (tmo_q < 6) ? int'(tmo_q) + 3 : 6);
                    repeat (run) begin
                        deliver_msg(KIND_TICK, 3'($urandom), pick_mask());
                        budget--;
                    end
                end else begin
                    if (r < 57)      deliver_msg(KIND_HELLO, 3'($urandom), pick_mask());
                    else if (r < 72) deliver_msg(KIND_ELECT, 3'($urandom), pick_mask());
                    else if (r < 82) deliver_msg(KIND_COORD, 3'($urandom), pick_mask());
                    else if (r < 92) deliver_msg(KIND_ALIVE, 3'($urandom), pick_mask());
                    else deliver_msg(3'($urandom_range(5, 7)), 3'($urandom), pick_mask());
                    budget--;
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin : sink_pacing
        int gap;
        @(posedge aresetn);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            msgs_checked++;
            if (expected_msgs.size() == 0) begin
                $display("%0t: unexpected beat dest_id %0d out_kind %0d last %0b",
                         $time, m_data.dest_id, m_data.out_kind, m_data.last);
                errors++;
            end else begin
                want = expected_msgs.pop_front();
                if (m_data.dest_id !== want.dest_id) begin
                    $display("%0t: dest_id expected %0d got %0d",
                             $time, want.dest_id, m_data.dest_id);
                    errors++;
                end
                if (m_data.out_kind !== want.out_kind) begin
                    $display("%0t: out_kind expected %0d got %0d",
                             $time, want.out_kind, m_data.out_kind);
                    errors++;
                end
                if (m_data.last !== want.last) begin
                    $display("%0t: last expected %0b got %0b",
                             $time, want.last, m_data.last);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stalled = 0;
            else stalled++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        check_reset_defaults();
        check_message_kinds();
        check_instability();
        check_idle_saturation();
        run_random_traffic();
        drain_node();
        $display("Sent %0d input beats across %0d node settings, checked %0d message beats.",
                 items_sent, settings_used, msgs_checked);
        $display("Covered hello, elections, coordinator, alive, unknown kinds, timeouts, "
                 , "instability and idle counter saturation.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### bully_election_node_core.f
rtl/core/ben_pkg.sv
rtl/core/ben_useq.sv
rtl/core/bully_election_node_core.sv
tb/bully_election_node_core_test.sv
